// ===== rtl/core/bvg_pkg.sv =====
// Shared constants for the battery voltage filter and gauge core:
// field widths, register indexes and the Li-ion open-circuit curve.
// No dependencies.
`default_nettype none

package bvg_pkg;

   localparam int SAMPLE_W = 13;
   localparam int FMV_W    = 14;
   localparam int PCT_W    = 7;
   localparam int FILT_W   = 22;
   localparam int CSR_AW   = 5;
   localparam int CSR_DW   = 32;
   localparam int CNT_W    = 5;

   localparam int CURVE_POINTS = 17;
   localparam int SEG_W        = $clog2(CURVE_POINTS);
   // widest curve segment is 60 mV, in Q8
   localparam int GAP_W        = 14;
   // largest percent drop across one segment is 10
   localparam int PD_W         = 4;
   localparam int NUM_W        = GAP_W + PD_W;

   localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

   localparam logic [2:0] REG_TRIM  = 3'd0;
   localparam logic [2:0] REG_ASLOW = 3'd1;
   localparam logic [2:0] REG_AFAST = 3'd2;
   localparam logic [2:0] REG_DELTA = 3'd3;
   localparam logic [2:0] REG_HYST  = 3'd4;
   localparam logic [2:0] REG_JUMP  = 3'd5;

   localparam logic [SAMPLE_W-1:0] CURVE_MV [CURVE_POINTS] = '{
      13'd4200, 13'd4150, 13'd4110, 13'd4080, 13'd4020, 13'd3980,
      13'd3950, 13'd3910, 13'd3870, 13'd3850, 13'd3840, 13'd3820,
      13'd3800, 13'd3790, 13'd3770, 13'd3730, 13'd3700
   };

   localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_POINTS] = '{
      7'd100, 7'd95, 7'd90, 7'd85, 7'd75, 7'd65, 7'd55, 7'd45,
      7'd35,  7'd30, 7'd25, 7'd20, 7'd15, 7'd10, 7'd5,  7'd2,
      7'd0
   };

endpackage

`default_nettype wire

// ===== rtl/core/bvg_req_if.sv =====
// Sample channel: valid/ready handshake carrying one voltage sample beat.
// Depends on bvg_pkg for field widths.
`default_nettype none

interface bvg_req_if;
   logic                          valid;
   logic                          ready;
   logic [bvg_pkg::SAMPLE_W-1:0]  sample_mv;
   logic                          restart;

   modport source (output valid, output sample_mv, output restart, input ready);
   modport sink   (input valid, input sample_mv, input restart, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bvg_rsp_if.sv =====
// Result channel: valid/ready handshake carrying one gauge result beat.
// Depends on bvg_pkg for field widths.
`default_nettype none

interface bvg_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [bvg_pkg::FMV_W-1:0]  filtered_mv;
   logic [bvg_pkg::PCT_W-1:0]  display_percent;
   logic                       valid_res;

   modport source (output valid, output filtered_mv, output display_percent,
                   output valid_res, input ready);
   modport sink   (input valid, input filtered_mv, input display_percent,
                   input valid_res, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/battery_voltage_filter_and_gauge_core.sv =====
// Battery voltage filter and gauge core: trim, EMA filter, curve lookup, display.
// Depends on bvg_pkg, bvg_req_if and bvg_rsp_if.
//
// One sample beat is taken at a time. A sample of 0 (unknown) goes straight to
// the done state. A valid sample passes through the bit-serial trim multiply,
// the bit-serial divide by 1000, the smoothing multiply (skipped for the sample
// that seeds the filter), the curve segment search and the interpolation
// multiply and divide (both skipped outside the curve), then the display update.
// The result sits in an output register, so the next sample is taken while a
// result still waits on rsp_bus.
`default_nettype none

module battery_voltage_filter_and_gauge_core (
   input  wire                         clock,
   input  wire                         reset,
   bvg_req_if.sink                     req_bus,
   bvg_rsp_if.source                   rsp_bus,
   input  wire                         psel,
   input  wire                         penable,
   input  wire                         pwrite,
   input  wire [bvg_pkg::CSR_AW-1:0]   paddr,
   input  wire [bvg_pkg::CSR_DW-1:0]   pwdata,
   output logic [bvg_pkg::CSR_DW-1:0]  prdata,
   output logic                        pready
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_MUL   = 4'd1;
   localparam logic [3:0] ST_DIV   = 4'd2;
   localparam logic [3:0] ST_FILT  = 4'd3;
   localparam logic [3:0] ST_STEP  = 4'd4;
   localparam logic [3:0] ST_RANGE = 4'd5;
   localparam logic [3:0] ST_SRCH  = 4'd6;
   localparam logic [3:0] ST_IMUL  = 4'd7;
   localparam logic [3:0] ST_IPREP = 4'd8;
   localparam logic [3:0] ST_IDIV  = 4'd9;
   localparam logic [3:0] ST_UPD   = 4'd10;
   localparam logic [3:0] ST_DONE  = 4'd11;

   localparam int SEGS = bvg_pkg::CURVE_POINTS - 1;

   logic [9:0] trim_ff,  trim_in;
   logic [7:0] aslow_ff, aslow_in;
   logic [7:0] afast_ff, afast_in;
   logic [9:0] delta_ff, delta_in;
   logic [3:0] hyst_ff,  hyst_in;
   logic [6:0] jump_ff,  jump_in;

   logic [3:0]                      state_ff, state_in;
   logic [bvg_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic                            seeded_ff, seeded_in;
   logic                            first_ff, first_in;
   logic [bvg_pkg::FILT_W-1:0]      filt_ff, filt_in;
   logic [bvg_pkg::PCT_W-1:0]       shown_ff, shown_in;
   logic [bvg_pkg::SAMPLE_W-1:0]    smp_ff, smp_in;
   logic [23:0]                     prod_ff, prod_in;
   logic [31:0]                     dvd_ff, dvd_in;
   logic [9:0]                      rem_ff, rem_in;
   logic [bvg_pkg::FILT_W-1:0]      quo_ff, quo_in;
   logic                            up_ff, up_in;
   logic [bvg_pkg::FILT_W-1:0]      mag_ff, mag_in;
   logic [7:0]                      alf_ff, alf_in;
   logic [29:0]                     acc_ff, acc_in;
   logic [bvg_pkg::SEG_W-1:0]       seg_ff, seg_in;
   logic [bvg_pkg::PCT_W-1:0]       target_ff, target_in;
   logic [bvg_pkg::GAP_W-1:0]       dv_ff, dv_in;
   logic [bvg_pkg::PD_W-1:0]        dp_ff, dp_in;
   logic [bvg_pkg::NUM_W-1:0]       inum_ff, inum_in;
   logic [bvg_pkg::NUM_W:0]         irem_ff, irem_in;
   logic [bvg_pkg::NUM_W-1:0]       idiv_ff, idiv_in;
   logic [bvg_pkg::PD_W-1:0]        iq_ff, iq_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [bvg_pkg::FMV_W-1:0]       rsp_fmv_ff, rsp_fmv_in;
   logic [bvg_pkg::PCT_W-1:0]       rsp_pct_ff, rsp_pct_in;
   logic                            rsp_vres_ff, rsp_vres_in;

   logic                            req_fire;
   logic                            csr_wr;
   logic [2:0]                      csr_idx;

   // combinational helpers
   logic signed [11:0]              trim_sx;
   logic signed [11:0]              trim_cl;
   logic signed [11:0]              scale_sx;
   logic [10:0]                     scale;
   logic [23:0]                     prod_nx;
   logic [10:0]                     div_t;
   logic                            div_ge;
   logic [bvg_pkg::FILT_W-1:0]      raw;
   logic                            raw_up;
   logic [bvg_pkg::FILT_W-1:0]      raw_mag;
   logic [29:0]                     acc_rnd;
   logic [bvg_pkg::FILT_W-1:0]      step;
   logic [bvg_pkg::SEG_W-1:0]       seg_nx;
   logic [20:0]                     lv;
   logic [bvg_pkg::SAMPLE_W-1:0]    gap_mv;
   logic [bvg_pkg::GAP_W-1:0]       den;
   logic [bvg_pkg::NUM_W-1:0]       inum_nx;
   logic                            idiv_ge;
   logic [bvg_pkg::PD_W-1:0]        iq_nx;
   logic [bvg_pkg::PCT_W-1:0]       tgt_sum;
   logic signed [8:0]               diff;
   logic signed [8:0]               hyst_s;
   logic signed [8:0]               jump_s;
   logic [bvg_pkg::FILT_W-1:0]      fmv_rnd;

   assign req_fire = req_bus.valid && req_bus.ready;
   assign csr_wr   = psel && penable && pwrite;
   assign csr_idx  = paddr[4:2];
   assign pready   = 1'b1;

   assign req_bus.ready           = (state_ff == ST_IDLE);
   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.filtered_mv     = rsp_fmv_ff;
   assign rsp_bus.display_percent = rsp_pct_ff;
   assign rsp_bus.valid_res       = rsp_vres_ff;

   always_comb begin
      prdata = '0;
      unique case (csr_idx)
         bvg_pkg::REG_TRIM:  prdata = {22'd0, trim_ff};
         bvg_pkg::REG_ASLOW: prdata = {24'd0, aslow_ff};
         bvg_pkg::REG_AFAST: prdata = {24'd0, afast_ff};
         bvg_pkg::REG_DELTA: prdata = {22'd0, delta_ff};
         bvg_pkg::REG_HYST:  prdata = {28'd0, hyst_ff};
         bvg_pkg::REG_JUMP:  prdata = {25'd0, jump_ff};
         default:            prdata = '0;
      endcase
   end

   always_comb begin
      trim_in  = trim_ff;
      aslow_in = aslow_ff;
      afast_in = afast_ff;
      delta_in = delta_ff;
      hyst_in  = hyst_ff;
      jump_in  = jump_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            bvg_pkg::REG_TRIM:  trim_in  = pwdata[9:0];
            bvg_pkg::REG_ASLOW: aslow_in = pwdata[7:0];
            bvg_pkg::REG_AFAST: afast_in = pwdata[7:0];
            bvg_pkg::REG_DELTA: delta_in = pwdata[9:0];
            bvg_pkg::REG_HYST:  hyst_in  = pwdata[3:0];
            bvg_pkg::REG_JUMP:  jump_in  = pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      trim_sx = {{2{trim_ff[9]}}, trim_ff};
      if (trim_sx < -12'sd500) begin
         trim_cl = -12'sd500;
      end else if (trim_sx > 12'sd500) begin
         trim_cl = 12'sd500;
      end else begin
         trim_cl = trim_sx;
      end
      scale_sx = trim_cl + 12'sd1000;
      scale    = scale_sx[10:0];

      prod_nx = {prod_ff[22:0], 1'b0} + (smp_ff[bvg_pkg::SAMPLE_W-1] ? {13'd0, scale} : 24'd0);

      div_t  = {rem_ff, dvd_ff[31]};
      div_ge = (div_t >= 11'd1000);
      raw    = {quo_ff[bvg_pkg::FILT_W-2:0], div_ge};
      raw_up = (raw >= filt_ff);
      raw_mag = raw_up ? raw - filt_ff : filt_ff - raw;

      acc_rnd = acc_ff + 30'd128;
      step    = acc_rnd[29:8];

      seg_nx = seg_ff + bvg_pkg::SEG_W'(1);
      lv     = {bvg_pkg::CURVE_MV[seg_nx], 8'h00};
      gap_mv = bvg_pkg::CURVE_MV[seg_ff] - bvg_pkg::CURVE_MV[seg_nx];
      den    = bvg_pkg::GAP_W'({gap_mv, 8'h00});

      inum_nx = {inum_ff[bvg_pkg::NUM_W-2:0], 1'b0}
              + (dp_ff[bvg_pkg::PD_W-1] ? bvg_pkg::NUM_W'(dv_ff) : '0);

      idiv_ge = (irem_ff >= {1'b0, idiv_ff});
      iq_nx   = {iq_ff[bvg_pkg::PD_W-2:0], idiv_ge};
      tgt_sum = bvg_pkg::CURVE_PCT[seg_nx] + bvg_pkg::PCT_W'(iq_nx);

      diff   = $signed({2'b00, target_ff}) - $signed({2'b00, shown_ff});
      hyst_s = (hyst_ff == 4'd0) ? 9'sd1 : $signed({5'd0, hyst_ff});
      jump_s = $signed({2'b00, jump_ff});

      fmv_rnd = filt_ff + bvg_pkg::FILT_W'(128);
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      seeded_in    = seeded_ff;
      first_in     = first_ff;
      filt_in      = filt_ff;
      shown_in     = shown_ff;
      smp_in       = smp_ff;
      prod_in      = prod_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      up_in        = up_ff;
      mag_in       = mag_ff;
      alf_in       = alf_ff;
      acc_in       = acc_ff;
      seg_in       = seg_ff;
      target_in    = target_ff;
      dv_in        = dv_ff;
      dp_in        = dp_ff;
      inum_in      = inum_ff;
      irem_in      = irem_ff;
      idiv_in      = idiv_ff;
      iq_in        = iq_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_fmv_in   = rsp_fmv_ff;
      rsp_pct_in   = rsp_pct_ff;
      rsp_vres_in  = rsp_vres_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_bus.restart) begin
                  seeded_in = 1'b0;
                  filt_in   = '0;
                  shown_in  = '0;
               end
               if (req_bus.sample_mv != '0) begin
                  smp_in   = req_bus.sample_mv;
                  prod_in  = '0;
                  cnt_in   = bvg_pkg::CNT_W'(bvg_pkg::SAMPLE_W - 1);
                  state_in = ST_MUL;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_MUL: begin
            prod_in = prod_nx;
            smp_in  = {smp_ff[bvg_pkg::SAMPLE_W-2:0], 1'b0};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               dvd_in   = {prod_nx, 8'h00} + 32'd500;
               rem_in   = '0;
               quo_in   = '0;
               cnt_in   = bvg_pkg::CNT_W'(31);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = div_ge ? 10'(div_t - 11'd1000) : div_t[9:0];
            quo_in = raw;
            dvd_in = {dvd_ff[30:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               if (!seeded_ff) begin
                  seeded_in = 1'b1;
                  first_in  = 1'b1;
                  filt_in   = raw;
                  state_in  = ST_RANGE;
               end else begin
                  first_in = 1'b0;
                  up_in    = raw_up;
                  mag_in   = raw_mag;
                  alf_in   = (raw_mag >= {4'd0, delta_ff, 8'h00}) ? afast_ff : aslow_ff;
                  acc_in   = '0;
                  cnt_in   = bvg_pkg::CNT_W'(7);
                  state_in = ST_FILT;
               end
            end
         end
         ST_FILT: begin
            acc_in = {acc_ff[28:0], 1'b0} + (alf_ff[7] ? {8'd0, mag_ff} : 30'd0);
            alf_in = {alf_ff[6:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            filt_in  = up_ff ? filt_ff + step : filt_ff - step;
            state_in = ST_RANGE;
         end
         ST_RANGE: begin
            if (filt_ff >= {1'b0, bvg_pkg::CURVE_MV[0], 8'h00}) begin
               target_in = bvg_pkg::PCT_MAX;
               state_in  = ST_UPD;
            end else if (filt_ff <= {1'b0, bvg_pkg::CURVE_MV[SEGS], 8'h00}) begin
               target_in = '0;
               state_in  = ST_UPD;
            end else begin
               seg_in   = '0;
               state_in = ST_SRCH;
            end
         end
         ST_SRCH: begin
            if (filt_ff >= {1'b0, lv}) begin
               dv_in    = bvg_pkg::GAP_W'(filt_ff - {1'b0, lv});
               dp_in    = bvg_pkg::PD_W'(bvg_pkg::CURVE_PCT[seg_ff]
                                         - bvg_pkg::CURVE_PCT[seg_nx]);
               inum_in  = '0;
               cnt_in   = bvg_pkg::CNT_W'(bvg_pkg::PD_W - 1);
               state_in = ST_IMUL;
            end else begin
               seg_in = seg_nx;
            end
         end
         ST_IMUL: begin
            inum_in = inum_nx;
            dp_in   = {dp_ff[bvg_pkg::PD_W-2:0], 1'b0};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_IPREP;
            end
         end
         ST_IPREP: begin
            irem_in  = {inum_ff, 1'b0} + (bvg_pkg::NUM_W + 1)'(den);
            idiv_in  = {den, {bvg_pkg::PD_W{1'b0}}};
            iq_in    = '0;
            cnt_in   = bvg_pkg::CNT_W'(bvg_pkg::PD_W - 1);
            state_in = ST_IDIV;
         end
         ST_IDIV: begin
            irem_in = idiv_ge ? irem_ff - {1'b0, idiv_ff} : irem_ff;
            idiv_in = {1'b0, idiv_ff[bvg_pkg::NUM_W-1:1]};
            iq_in   = iq_nx;
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               target_in = (tgt_sum > bvg_pkg::PCT_MAX) ? bvg_pkg::PCT_MAX : tgt_sum;
               state_in  = ST_UPD;
            end
         end
         ST_UPD: begin
            if (first_ff) begin
               shown_in = target_ff;
            end else if (diff >= hyst_s) begin
               if (diff >= jump_s) begin
                  shown_in = target_ff;
               end else if (shown_ff < bvg_pkg::PCT_MAX) begin
                  shown_in = shown_ff + 1'b1;
               end
            end else if (diff <= -hyst_s) begin
               if (diff <= -jump_s) begin
                  shown_in = target_ff;
               end else if (shown_ff > '0) begin
                  shown_in = shown_ff - 1'b1;
               end
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_vres_in  = seeded_ff;
               rsp_fmv_in   = seeded_ff ? fmv_rnd[bvg_pkg::FILT_W-1:8] : '0;
               rsp_pct_in   = seeded_ff ? shown_ff : '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trim_ff      <= '0;
         aslow_ff     <= 8'd46;
         afast_ff     <= 8'd115;
         delta_ff     <= 10'd80;
         hyst_ff      <= 4'd2;
         jump_ff      <= 7'd6;
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         seeded_ff    <= 1'b0;
         first_ff     <= 1'b0;
         filt_ff      <= '0;
         shown_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         trim_ff      <= trim_in;
         aslow_ff     <= aslow_in;
         afast_ff     <= afast_in;
         delta_ff     <= delta_in;
         hyst_ff      <= hyst_in;
         jump_ff      <= jump_in;
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         seeded_ff    <= seeded_in;
         first_ff     <= first_in;
         filt_ff      <= filt_in;
         shown_ff     <= shown_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      smp_ff      <= smp_in;
      prod_ff     <= prod_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      up_ff       <= up_in;
      mag_ff      <= mag_in;
      alf_ff      <= alf_in;
      acc_ff      <= acc_in;
      seg_ff      <= seg_in;
      target_ff   <= target_in;
      dv_ff       <= dv_in;
      dp_ff       <= dp_in;
      inum_ff     <= inum_in;
      irem_ff     <= irem_in;
      idiv_ff     <= idiv_in;
      iq_ff       <= iq_in;
      rsp_fmv_ff  <= rsp_fmv_in;
      rsp_pct_ff  <= rsp_pct_in;
      rsp_vres_ff <= rsp_vres_in;
   end

`ifndef SYNTHESIS
   a_shown_range: assert property (@(posedge clock) disable iff (reset)
      shown_ff <= bvg_pkg::PCT_MAX)
      else $error("displayed percent above full scale");

   a_unseeded_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_vres_ff |-> rsp_fmv_ff == '0 && rsp_pct_ff == '0)
      else $error("result fields not cleared before seeding");

   a_load_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result beat loaded outside the done state");

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_bus.restart && req_bus.sample_mv == '0
      |=> !seeded_ff && state_ff == ST_DONE)
      else $error("restart with unknown sample left filter seeded");

   a_fmv_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_fmv_ff <= 14'd12287)
      else $error("filtered voltage beyond trimmed full scale");
`endif

endmodule

`default_nettype wire

// ===== verif/bvg_gauge_checker.sv =====
`timescale 1ns / 1ps
// Gauge checker: watches the sample, result and register ports of the gauge core,
// predicts each result from its own copy of filter state and registers, and compares.
// Depends on bvg_pkg, bvg_req_if and bvg_rsp_if.

module bvg_gauge_checker (
   input  wire                         clock,
   input  wire                         reset,
   bvg_req_if                          req_mon,
   bvg_rsp_if                          rsp_mon,
   input  wire                         psel,
   input  wire                         penable,
   input  wire                         pwrite,
   input  wire [bvg_pkg::CSR_AW-1:0]   paddr,
   input  wire [bvg_pkg::CSR_DW-1:0]   pwdata,
   input  wire [bvg_pkg::CSR_DW-1:0]   prdata,
   input  wire                         pready,
   output int                          fail_count,
   output int                          outstanding
);
   import bvg_pkg::*;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample_mv;
      logic                restart;
   } sample_t;

   typedef struct packed {
      logic [FMV_W-1:0] filtered_mv;
      logic [PCT_W-1:0] display_percent;
      logic             valid_res;
   } gauge_t;

   logic [9:0]        cfg_trim;
   logic [7:0]        cfg_aslow;
   logic [7:0]        cfg_afast;
   logic [9:0]        cfg_delta;
   logic [3:0]        cfg_hyst;
   logic [6:0]        cfg_jump;

   logic              seeded;
   logic [FILT_W-1:0] filt_q8;
   logic [PCT_W-1:0]  shown_pct;

   gauge_t            pending_gauge_q [$];

   function automatic int curve_target(input longint vq8);
      longint hv;
      longint lv;
      longint num;
      longint den;
      longint pct;
      if (vq8 == 0) return 0;
      if (vq8 >= longint'(CURVE_MV[0]) * 256) return 100;
      if (vq8 <= longint'(CURVE_MV[CURVE_POINTS-1]) * 256) return 0;
      for (int i = 0; i + 1 < CURVE_POINTS; i++) begin
         hv = longint'(CURVE_MV[i]) * 256;
         lv = longint'(CURVE_MV[i+1]) * 256;
         if (vq8 <= hv && vq8 >= lv) begin
            if (hv <= lv) return int'(CURVE_PCT[i+1]);
            den = hv - lv;
            num = (longint'(CURVE_PCT[i]) - longint'(CURVE_PCT[i+1])) * (vq8 - lv);
            pct = longint'(CURVE_PCT[i+1]) + (2 * num + den) / (2 * den);
            return (pct > 100) ? 100 : int'(pct);
         end
      end
      return 0;
   endfunction

   function automatic gauge_t gauge_predict(input sample_t s);
      longint trim;
      longint raw;
      longint mag;
      longint alpha;
      longint stp;
      int     hyst;
      int     target;
      int     diff;
      int     fmv;
      logic   up;
      gauge_t r;
      if (s.restart) begin
         seeded    = 1'b0;
         filt_q8   = '0;
         shown_pct = '0;
      end
      if (s.sample_mv != 0) begin
         trim = $signed(cfg_trim);
         if (trim < -500) trim = -500;
         if (trim > 500) trim = 500;
         raw = (longint'(s.sample_mv) * (1000 + trim) * 256 + 500) / 1000;
         if (!seeded) begin
            seeded    = 1'b1;
            filt_q8   = raw[FILT_W-1:0];
            shown_pct = PCT_W'(curve_target(raw));
         end else begin
            up    = raw >= longint'(filt_q8);
            mag   = up ? raw - longint'(filt_q8) : longint'(filt_q8) - raw;
            alpha = (mag >= longint'(cfg_delta) * 256) ? longint'(cfg_afast)
                                                        : longint'(cfg_aslow);
            stp   = (mag * alpha + 128) >> 8;
            if (stp > mag) stp = mag;
            filt_q8 = up ? filt_q8 + stp[FILT_W-1:0] : filt_q8 - stp[FILT_W-1:0];
            hyst    = (cfg_hyst == 0) ? 1 : int'(cfg_hyst);
            target  = curve_target(longint'(filt_q8));
            diff    = target - int'(shown_pct);
            if (diff >= hyst) begin
               if (diff >= int'(cfg_jump)) shown_pct = PCT_W'(target);
               else if (shown_pct < PCT_MAX) shown_pct = shown_pct + 1'b1;
            end else if (diff <= -hyst) begin
               if (diff <= -int'(cfg_jump)) shown_pct = PCT_W'(target);
               else if (shown_pct > 0) shown_pct = shown_pct - 1'b1;
            end
         end
      end
      if (seeded) begin
         fmv               = (int'(filt_q8) + 128) >> 8;
         r.filtered_mv     = fmv[FMV_W-1:0];
         r.display_percent = shown_pct;
         r.valid_res       = 1'b1;
      end else begin
         r = '0;
      end
      return r;
   endfunction

   function automatic void flag_failure(input string what);
      if (fail_count < 10) $display("%0t: %s", $realtime, what);
      fail_count++;
   endfunction

   always @(posedge clock) begin
      sample_t    beat;
      gauge_t     want;
      gauge_t     got;
      logic [2:0] idx;
      logic       read_ok;
      idx = paddr[CSR_AW-1:2];
      if (reset) begin
         cfg_trim  = 10'd0;
         cfg_aslow = 8'd46;
         cfg_afast = 8'd115;
         cfg_delta = 10'd80;
         cfg_hyst  = 4'd2;
         cfg_jump  = 7'd6;
         seeded    = 1'b0;
         filt_q8   = '0;
         shown_pct = '0;
         pending_gauge_q.delete();
         outstanding <= 0;
      end else begin
         if (psel && penable && pready && pwrite) begin
            case (idx)
               REG_TRIM:  cfg_trim  = pwdata[9:0];
               REG_ASLOW: cfg_aslow = pwdata[7:0];
               REG_AFAST: cfg_afast = pwdata[7:0];
               REG_DELTA: cfg_delta = pwdata[9:0];
               REG_HYST:  cfg_hyst  = pwdata[3:0];
               REG_JUMP:  cfg_jump  = pwdata[6:0];
               default: ;
            endcase
         end
         if (psel && penable && pready && !pwrite) begin
            case (idx)
               REG_TRIM:  read_ok = prdata[9:0] === cfg_trim;
               REG_ASLOW: read_ok = prdata[7:0] === cfg_aslow;
               REG_AFAST: read_ok = prdata[7:0] === cfg_afast;
               REG_DELTA: read_ok = prdata[9:0] === cfg_delta;
               REG_HYST:  read_ok = prdata[3:0] === cfg_hyst;
               REG_JUMP:  read_ok = prdata[6:0] === cfg_jump;
               default:   read_ok = 1'b1;
            endcase
            if (!read_ok)
               flag_failure($sformatf("register %0d read back 0x%0h", idx, prdata));
         end
         if (req_mon.valid && req_mon.ready) begin
            beat.sample_mv = req_mon.sample_mv;
            beat.restart   = req_mon.restart;
            pending_gauge_q.push_back(gauge_predict(beat));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.filtered_mv     = rsp_mon.filtered_mv;
            got.display_percent = rsp_mon.display_percent;
            got.valid_res       = rsp_mon.valid_res;
            if (pending_gauge_q.size() == 0) begin
               flag_failure($sformatf("result beat with nothing pending: mv=%0d pct=%0d v=%0d",
                  got.filtered_mv, got.display_percent, got.valid_res));
            end else begin
               want = pending_gauge_q.pop_front();
               if (got.filtered_mv !== want.filtered_mv ||
                   got.display_percent !== want.display_percent ||
                   got.valid_res !== want.valid_res)
                  flag_failure($sformatf(
                     "result mismatch: want mv=%0d pct=%0d v=%0d, got mv=%0d pct=%0d v=%0d",
                     want.filtered_mv, want.display_percent, want.valid_res,
                     got.filtered_mv, got.display_percent, got.valid_res));
            end
         end
         outstanding <= pending_gauge_q.size();
      end
   end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the battery voltage filter and gauge core: clock, reset, sample
// and register stimulus, result back-pressure and the verdict.
// Depends on bvg_pkg, bvg_req_if, bvg_rsp_if and bvg_gauge_checker.

module tb;
   import bvg_pkg::*;

   localparam int LONG_HOLD  = 400;
   localparam int PHASE_LEN  = 50;
   localparam int DIR_COUNT  = 25;
   localparam int DIR_MV [DIR_COUNT] = '{
      0, 0, 4250, 4250, 3600, 3600, 3600, 3910, 3910, 3915, 0, 0, 3870,
      3880, 3890, 3900, 8191, 1, 8191, 4200, 3700, 3730, 4150, 5461, 2730
   };
   localparam bit DIR_RESTART [DIR_COUNT] = '{
      0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1,
      0, 0, 0, 0, 1, 0, 1, 1, 0, 1, 0, 0
   };

   logic              clock;
   logic              reset;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [CSR_AW-1:0] paddr;
   logic [CSR_DW-1:0] pwdata;
   logic [CSR_DW-1:0] prdata;
   logic              pready;

   int fail_count;
   int outstanding;
   int trim_now;
   int walk_mv;
   int burst_left;
   bit hold_results;

   bvg_req_if req_bus ();
   bvg_rsp_if rsp_bus ();

   battery_voltage_filter_and_gauge_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   bvg_gauge_checker gauge_chk (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #16_000_000;
      $display("[battery_voltage_filter_and_gauge_core] ERROR");
      $finish;
   end

   // result side: stall patterns, plus one long hold on request
   initial begin
      int mode;
      int left;
      int n;
      mode = 0;
      left = 0;
      n    = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_results) begin
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_results = 1'b0;
         end else begin
            if (left == 0) begin
               mode = $urandom_range(0, 3);
               left = $urandom_range(10, 120);
            end
            left--;
            n++;
            case (mode)
               0:       rsp_bus.ready <= 1'b1;
               1:       rsp_bus.ready <= $urandom_range(0, 1);
               2:       rsp_bus.ready <= ($urandom_range(0, 4) == 0);
               default: rsp_bus.ready <= (n % 3) != 0;
            endcase
         end
      end
   end

   task automatic send_beat(input logic [SAMPLE_W-1:0] mv, input logic rst);
      req_bus.valid     <= 1'b1;
      req_bus.sample_mv <= mv;
      req_bus.restart   <= rst;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // send one beat, then close the burst with a random gap when it runs out
   task automatic offer(input logic [SAMPLE_W-1:0] mv, input logic rst);
      int gap;
      send_beat(mv, rst);
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 10);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [CSR_DW-1:0] val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
   endtask

   task automatic csr_read(input logic [2:0] idx);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
   endtask

   function automatic logic [CSR_DW-1:0] with_noise(input logic [CSR_DW-1:0] val,
                                                    input logic [CSR_DW-1:0] mask);
      return ($urandom() & ~mask) | (val & mask);
   endfunction

   task automatic set_gauge_config(input logic [9:0] trim, input logic [7:0] slow_w,
                                   input logic [7:0] fast_w, input logic [9:0] delta,
                                   input logic [3:0] hyst, input logic [6:0] jump);
      drain();
      csr_write(REG_TRIM,  with_noise(CSR_DW'(trim),   32'h3FF));
      csr_write(REG_ASLOW, with_noise(CSR_DW'(slow_w), 32'hFF));
      csr_write(REG_AFAST, with_noise(CSR_DW'(fast_w), 32'hFF));
      csr_write(REG_DELTA, with_noise(CSR_DW'(delta),  32'h3FF));
      csr_write(REG_HYST,  with_noise(CSR_DW'(hyst),   32'hF));
      csr_write(REG_JUMP,  with_noise(CSR_DW'(jump),   32'h7F));
      for (int k = REG_TRIM; k <= REG_JUMP; k++) csr_read(k[2:0]);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      trim_now = $signed(trim);
      if (trim_now < -500) trim_now = -500;
      if (trim_now > 500) trim_now = 500;
   endtask

   // raw sample that lands near a given trimmed voltage
   function automatic logic [SAMPLE_W-1:0] sample_for(input int mv);
      int s;
      s = (mv * 1000 + (1000 + trim_now) / 2) / (1000 + trim_now);
      if (s < 1) s = 1;
      if (s > 8191) s = 8191;
      return s[SAMPLE_W-1:0];
   endfunction

   task automatic random_item();
      int                  pick;
      logic [SAMPLE_W-1:0] mv;
      logic                rst;
      pick = $urandom_range(0, 99);
      rst  = ($urandom_range(0, 29) == 0);
      if (pick < 8) begin
         mv = '0;
      end else if (pick < 18) begin
         mv = $urandom_range(1, 8191);
      end else if (pick < 24) begin
         mv = sample_for(int'(CURVE_MV[$urandom_range(0, CURVE_POINTS - 1)]));
      end else begin
         if (pick < 32) walk_mv = $urandom_range(3550, 4350);
         else walk_mv = walk_mv + int'($urandom_range(0, 40)) - 20;
         if (walk_mv < 3550) walk_mv = 3550;
         if (walk_mv > 4350) walk_mv = 4350;
         mv = sample_for(walk_mv);
      end
      offer(mv, rst);
   endtask

   initial begin
      reset             <= 1'b1;
      psel              <= 1'b0;
      penable           <= 1'b0;
      pwrite            <= 1'b0;
      paddr             <= '0;
      pwdata            <= '0;
      req_bus.valid     <= 1'b0;
      req_bus.sample_mv <= '0;
      req_bus.restart   <= 1'b0;
      trim_now          = 0;
      walk_mv           = 3950;
      burst_left        = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_COUNT; i++) offer(SAMPLE_W'(DIR_MV[i]), DIR_RESTART[i]);

      set_gauge_config(10'h200, 8'd0, 8'd255, 10'd0, 4'd0, 7'd0);
      repeat (PHASE_LEN) random_item();

      set_gauge_config(10'h1FF, 8'd255, 8'd0, 10'd1023, 4'd15, 7'd127);
      repeat (10) random_item();
      hold_results = 1'b1;
      repeat (PHASE_LEN - 10) random_item();

      set_gauge_config(10'h20C, 8'd1, 8'd128, 10'd1, 4'd1, 7'd100);
      repeat (PHASE_LEN) random_item();

      set_gauge_config(10'h1F4, 8'd46, 8'd115, 10'd80, 4'd2, 7'd101);
      repeat (PHASE_LEN / 2) random_item();
      drain();
      repeat (PHASE_LEN / 2) random_item();

      repeat (4) begin
         set_gauge_config($urandom_range(0, 1023), $urandom_range(0, 255),
                          $urandom_range(0, 255), $urandom_range(0, 1023),
                          $urandom_range(0, 15), $urandom_range(0, 127));
         repeat (PHASE_LEN) random_item();
      end

      begin
         int waited;
         waited = 0;
         req_bus.valid <= 1'b0;
         do begin
            @(posedge clock);
            waited++;
         end while (outstanding != 0 && waited < 20000);
         repeat (200) @(posedge clock);
         if (fail_count == 0 && outstanding == 0)
            $display("[battery_voltage_filter_and_gauge_core] OK");
         else
            $display("[battery_voltage_filter_and_gauge_core] ERROR");
         $finish;
      end
   end

endmodule
